[design/cabb_pkg.sv]
// Package for the clipped alpha-blend blitter: surface geometry, register
// indexes and the types shared by the walker, the lanes and the top level.
// Depends on nothing.
`default_nettype none

package cabb_pkg;

   // Surface geometry.
   localparam int SRC_COLS            = 1024;
   localparam int SRC_ROWS            = 1024;
   localparam int DST_COLS            = 1024;
   localparam int DST_ROWS            = 1024;
   localparam int SRC_BYTES_PER_PIXEL = 4;
   localparam int DST_BYTES_PER_PIXEL = 4;

   // Channels at or beyond the smaller pixel size pass the destination through.
   localparam int MIN_BYTES_PER_PIXEL =
      (SRC_BYTES_PER_PIXEL < DST_BYTES_PER_PIXEL) ? SRC_BYTES_PER_PIXEL
                                                  : DST_BYTES_PER_PIXEL;

   localparam int NUM_LANES  = 4;
   localparam int CH_WIDTH   = 8;
   localparam int POS_WIDTH  = 11;
   localparam int IDX_WIDTH  = 21;
   localparam int ADDR_WIDTH = 22;
   localparam int CSR_AWIDTH = 5;

   // Register indexes (byte address divided by four).
   localparam logic [2:0] REG_SRC_X        = 3'd0;
   localparam logic [2:0] REG_SRC_Y        = 3'd1;
   localparam logic [2:0] REG_DST_X        = 3'd2;
   localparam logic [2:0] REG_DST_Y        = 3'd3;
   localparam logic [2:0] REG_COPY_WIDTH   = 3'd4;
   localparam logic [2:0] REG_COPY_HEIGHT  = 3'd5;
   localparam logic [2:0] REG_BLEND_ENABLE = 3'd6;
   localparam logic [2:0] REG_ALPHA        = 3'd7;

   typedef logic [CH_WIDTH-1:0] ch_type;

   typedef struct packed {
      logic signed [10:0] src_x;
      logic signed [10:0] src_y;
      logic signed [10:0] dst_x;
      logic signed [10:0] dst_y;
      logic [11:0]        copy_width;
      logic [11:0]        copy_height;
   } cfg_type;

   // Pixel position that the walker hands to the datapath.
   typedef struct packed {
      logic                 valid;
      logic [POS_WIDTH-1:0] sx;
      logic [POS_WIDTH-1:0] sy;
      logic [POS_WIDTH-1:0] dx;
      logic [POS_WIDTH-1:0] dy;
      logic                 last;
   } pos_type;

endpackage

`default_nettype wire

[design/cabb_req_if.sv]
// Input channel of the blitter: one word per pixel with the source and
// destination channels and the restart flag. Depends on nothing.
`default_nettype none

interface cabb_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic [7:0] src_ch0;
   logic [7:0] src_ch1;
   logic [7:0] src_ch2;
   logic [7:0] src_ch3;
   logic [7:0] dst_ch0;
   logic [7:0] dst_ch1;
   logic [7:0] dst_ch2;
   logic [7:0] dst_ch3;

   modport source (
      output valid, start_req, src_ch0, src_ch1, src_ch2, src_ch3,
             dst_ch0, dst_ch1, dst_ch2, dst_ch3,
      input  ready
   );

   modport sink (
      input  valid, start_req, src_ch0, src_ch1, src_ch2, src_ch3,
             dst_ch0, dst_ch1, dst_ch2, dst_ch3,
      output ready
   );
endinterface

`default_nettype wire

[design/cabb_rsp_if.sv]
// Result channel of the blitter: channels to write, both byte addresses and
// the end-of-area flag. Depends on nothing.
`default_nettype none

interface cabb_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_ch0;
   logic [7:0]  out_ch1;
   logic [7:0]  out_ch2;
   logic [7:0]  out_ch3;
   logic [21:0] src_address;
   logic [21:0] dst_address;
   logic        last;

   modport source (
      output valid, out_ch0, out_ch1, out_ch2, out_ch3,
             src_address, dst_address, last,
      input  ready
   );

   modport sink (
      input  valid, out_ch0, out_ch1, out_ch2, out_ch3,
             src_address, dst_address, last,
      output ready
   );
endinterface

`default_nettype wire

[design/cabb_walker.sv]
// Clipping and raster walk of the blitter: works out the clipped area from
// the registers and steps column and row once per accepted word.
// Depends on cabb_pkg.
`default_nettype none

module cabb_walker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cabb_pkg::cfg_type cfg,
   input  wire logic              accept,
   input  wire logic              load,
   input  wire logic              start_req,
   output cabb_pkg::pos_type      pos
);

   typedef struct packed {
      logic [10:0] len;
      logic [10:0] sbeg;
      logic [10:0] dbeg;
   } span_type;

   localparam logic signed [13:0] SRC_W_S = 14'(cabb_pkg::SRC_COLS);
   localparam logic signed [13:0] SRC_H_S = 14'(cabb_pkg::SRC_ROWS);
   localparam logic signed [13:0] DST_W_S = 14'(cabb_pkg::DST_COLS);
   localparam logic signed [13:0] DST_H_S = 14'(cabb_pkg::DST_ROWS);

   // Both spans are clamped at zero and at their surface edge; the clipped
   // length is the shorter of the two.
   function automatic span_type clip_span(
      input logic signed [10:0] s,
      input logic signed [10:0] d,
      input logic [11:0]        n,
      input logic signed [13:0] slim,
      input logic signed [13:0] dlim
   );
      logic signed [13:0] se, de, ne, sl, dl, sr, dr, sn, dn;
      span_type r;
      se = 14'(s);
      de = 14'(d);
      ne = $signed({2'b00, n});
      sl = (se < 0) ? 14'sd0 : se;
      dl = (de < 0) ? 14'sd0 : de;
      sr = (se + ne < slim) ? se + ne : slim;
      dr = (de + ne < dlim) ? de + ne : dlim;
      sn = sr - sl;
      dn = dr - dl;
      r.sbeg = sl[10:0];
      r.dbeg = dl[10:0];
      if (sn <= 0 || dn <= 0) begin
         r.len = 11'd0;
      end else if (sn < dn) begin
         r.len = sn[10:0];
      end else begin
         r.len = dn[10:0];
      end
      return r;
   endfunction

   span_type xs, ys;
   logic [10:0] column_ff, column_in;
   logic [10:0] row_ff, row_in;
   logic        running_ff, running_in;
   logic [10:0] col_c, row_c;
   logic        run_c, in_area, is_last, col_end;
   cabb_pkg::pos_type pos_ff, pos_in;

   always_comb begin
      xs = clip_span(cfg.src_x, cfg.dst_x, cfg.copy_width, SRC_W_S, DST_W_S);
      ys = clip_span(cfg.src_y, cfg.dst_y, cfg.copy_height, SRC_H_S, DST_H_S);

      col_c = start_req ? 11'd0 : column_ff;
      row_c = start_req ? 11'd0 : row_ff;
      run_c = start_req | running_ff;

      in_area = (xs.len != 11'd0) && (ys.len != 11'd0) &&
                (col_c < xs.len) && (row_c < ys.len);
      col_end = ({1'b0, col_c} + 12'd1) == {1'b0, xs.len};
      is_last = col_end && (({1'b0, row_c} + 12'd1) == {1'b0, ys.len});

      column_in  = column_ff;
      row_in     = row_ff;
      running_in = running_ff;
      if (accept) begin
         column_in  = col_c;
         row_in     = row_c;
         running_in = run_c;
         if (run_c && !in_area) begin
            running_in = 1'b0;
         end else if (run_c && is_last) begin
            running_in = 1'b0;
            column_in  = 11'd0;
            row_in     = 11'd0;
         end else if (run_c && col_end) begin
            column_in = 11'd0;
            row_in    = row_c + 11'd1;
         end else if (run_c) begin
            column_in = col_c + 11'd1;
         end
      end

      pos_in.valid = accept && run_c && in_area;
      pos_in.sx    = xs.sbeg + col_c;
      pos_in.sy    = ys.sbeg + row_c;
      pos_in.dx    = xs.dbeg + col_c;
      pos_in.dy    = ys.dbeg + row_c;
      pos_in.last  = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= 11'd0;
         row_ff       <= 11'd0;
         running_ff   <= 1'b0;
         pos_ff.valid <= 1'b0;
      end else begin
         column_ff  <= column_in;
         row_ff     <= row_in;
         running_ff <= running_in;
         if (load) begin
            pos_ff.valid <= pos_in.valid;
         end
      end
      if (load) begin
         pos_ff.sx   <= pos_in.sx;
         pos_ff.sy   <= pos_in.sy;
         pos_ff.dx   <= pos_in.dx;
         pos_ff.dy   <= pos_in.dy;
         pos_ff.last <= pos_in.last;
      end
   end

   assign pos = pos_ff;

endmodule

`default_nettype wire

[design/cabb_lane.sv]
// One channel lane of the blitter: plain copy, weighted mix of source over
// destination, or destination pass-through. Depends on cabb_pkg.
`default_nettype none

module cabb_lane (
   input  wire cabb_pkg::ch_type src_ch,
   input  wire cabb_pkg::ch_type dst_ch,
   input  wire logic [7:0]       alpha,
   input  wire logic             blend,
   input  wire logic             pass_dst,
   output cabb_pkg::ch_type      out_ch
);

   logic [8:0]  ws, wd;
   logic [16:0] ps, pd;
   logic [17:0] sum;

   always_comb begin
      ws  = {1'b0, alpha} + 9'd1;
      wd  = 9'd256 - {1'b0, alpha};
      ps  = {9'b0, src_ch} * {8'b0, ws};
      pd  = {9'b0, dst_ch} * {8'b0, wd};
      sum = {1'b0, ps} + {1'b0, pd};
      if (pass_dst) begin
         out_ch = dst_ch;
      end else if (blend) begin
         // The two weights add to 257, so the sum stays below 2^16.
         out_ch = sum[15:8];
      end else begin
         out_ch = src_ch;
      end
   end

endmodule

`default_nettype wire

[design/clipped_alpha_blend_blitter.sv]
// Top level of the clipped alpha-blend blitter: register port, raster
// walker, four channel lanes and the stage that merges lanes and addresses.
// Depends on cabb_pkg, cabb_req_if, cabb_rsp_if, cabb_walker and cabb_lane.
//
//   channel   direction  handshake        word
//   req_chan  in         valid / ready    start_req, src_ch0..3, dst_ch0..3
//   rsp_chan  out        valid / ready    out_ch0..3, src/dst_address, last
//   csr_*     in         APB write/read   eight registers at 4*index
//
// One word is accepted per clock unless stalled; it passes the walk, lane mix
// and pixel index, and byte address stages. Each stage holds only while the
// stage after it is full and stalled, so empty stages keep taking words.
// Synchronous reset clears the walk, valid flags and registers; alpha is 255.
`default_nettype none

module clipped_alpha_blend_blitter (
   input  wire logic        clock,
   input  wire logic        reset,
   cabb_req_if.sink         req_chan,
   cabb_rsp_if.source       rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int NL = cabb_pkg::NUM_LANES;

   // Register port.
   cabb_pkg::cfg_type cfg_ff;
   logic       blend_ff;
   logic [7:0] alpha_ff;
   logic [2:0] csr_index;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '0;
         blend_ff <= 1'b0;
         alpha_ff <= 8'd255;
      end else if (csr_write) begin
         case (csr_index)
            cabb_pkg::REG_SRC_X:        cfg_ff.src_x       <= csr_pwdata[10:0];
            cabb_pkg::REG_SRC_Y:        cfg_ff.src_y       <= csr_pwdata[10:0];
            cabb_pkg::REG_DST_X:        cfg_ff.dst_x       <= csr_pwdata[10:0];
            cabb_pkg::REG_DST_Y:        cfg_ff.dst_y       <= csr_pwdata[10:0];
            cabb_pkg::REG_COPY_WIDTH:   cfg_ff.copy_width  <= csr_pwdata[11:0];
            cabb_pkg::REG_COPY_HEIGHT:  cfg_ff.copy_height <= csr_pwdata[11:0];
            cabb_pkg::REG_BLEND_ENABLE: blend_ff           <= csr_pwdata[0];
            cabb_pkg::REG_ALPHA:        alpha_ff           <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         cabb_pkg::REG_SRC_X:        csr_prdata = {21'b0, cfg_ff.src_x};
         cabb_pkg::REG_SRC_Y:        csr_prdata = {21'b0, cfg_ff.src_y};
         cabb_pkg::REG_DST_X:        csr_prdata = {21'b0, cfg_ff.dst_x};
         cabb_pkg::REG_DST_Y:        csr_prdata = {21'b0, cfg_ff.dst_y};
         cabb_pkg::REG_COPY_WIDTH:   csr_prdata = {20'b0, cfg_ff.copy_width};
         cabb_pkg::REG_COPY_HEIGHT:  csr_prdata = {20'b0, cfg_ff.copy_height};
         cabb_pkg::REG_BLEND_ENABLE: csr_prdata = {31'b0, blend_ff};
         cabb_pkg::REG_ALPHA:        csr_prdata = {24'b0, alpha_ff};
         default:                    csr_prdata = 32'b0;
      endcase
   end

   // Stage enables: a stage loads when it is empty or its successor loads.
   logic en1, en2, en3, accept;
   logic v2_ff, v3_ff;
   cabb_pkg::pos_type pos1;

   assign en3    = !v3_ff || rsp_chan.ready;
   assign en2    = !v2_ff || en3;
   assign en1    = !pos1.valid || en2;
   assign accept = req_chan.valid && en1;
   assign req_chan.ready = en1;

   // Stage 1: walk, with the channels held alongside.
   cabb_pkg::ch_type src1_ff [NL];
   cabb_pkg::ch_type dst1_ff [NL];
   cabb_pkg::ch_type src_in  [NL];
   cabb_pkg::ch_type dst_in  [NL];

   assign src_in[0] = req_chan.src_ch0;
   assign src_in[1] = req_chan.src_ch1;
   assign src_in[2] = req_chan.src_ch2;
   assign src_in[3] = req_chan.src_ch3;
   assign dst_in[0] = req_chan.dst_ch0;
   assign dst_in[1] = req_chan.dst_ch1;
   assign dst_in[2] = req_chan.dst_ch2;
   assign dst_in[3] = req_chan.dst_ch3;

   cabb_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .load      (en1),
      .start_req (req_chan.start_req),
      .pos       (pos1)
   );

   always_ff @(posedge clock) begin
      if (en1) begin
         src1_ff <= src_in;
         dst1_ff <= dst_in;
      end
   end

   // Stage 2: lanes and pixel indexes.
   cabb_pkg::ch_type lane_out [NL];
   cabb_pkg::ch_type out2_ff  [NL];
   logic [cabb_pkg::IDX_WIDTH-1:0] src_idx2_ff, src_idx_in;
   logic [cabb_pkg::IDX_WIDTH-1:0] dst_idx2_ff, dst_idx_in;
   logic last2_ff;

   for (genvar i = 0; i < NL; i++) begin : g_lane
      cabb_lane u_lane (
         .src_ch   (src1_ff[i]),
         .dst_ch   (dst1_ff[i]),
         .alpha    (alpha_ff),
         .blend    (blend_ff),
         .pass_dst (i >= cabb_pkg::MIN_BYTES_PER_PIXEL),
         .out_ch   (lane_out[i])
      );
   end

   assign src_idx_in = cabb_pkg::IDX_WIDTH'(32'(pos1.sy) * cabb_pkg::SRC_COLS
                                            + 32'(pos1.sx));
   assign dst_idx_in = cabb_pkg::IDX_WIDTH'(32'(pos1.dy) * cabb_pkg::DST_COLS
                                            + 32'(pos1.dx));

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= pos1.valid;
      end
      if (en2) begin
         out2_ff     <= lane_out;
         src_idx2_ff <= src_idx_in;
         dst_idx2_ff <= dst_idx_in;
         last2_ff    <= pos1.last;
      end
   end

   // Stage 3: byte addresses merged with the lane results.
   cabb_pkg::ch_type out3_ff [NL];
   logic [cabb_pkg::ADDR_WIDTH-1:0] src_addr3_ff, src_addr_in;
   logic [cabb_pkg::ADDR_WIDTH-1:0] dst_addr3_ff, dst_addr_in;
   logic last3_ff;

   assign src_addr_in = cabb_pkg::ADDR_WIDTH'(32'(src_idx2_ff)
                                              * cabb_pkg::SRC_BYTES_PER_PIXEL);
   assign dst_addr_in = cabb_pkg::ADDR_WIDTH'(32'(dst_idx2_ff)
                                              * cabb_pkg::DST_BYTES_PER_PIXEL);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
      if (en3) begin
         out3_ff      <= out2_ff;
         src_addr3_ff <= src_addr_in;
         dst_addr3_ff <= dst_addr_in;
         last3_ff     <= last2_ff;
      end
   end

   assign rsp_chan.valid       = v3_ff;
   assign rsp_chan.out_ch0     = out3_ff[0];
   assign rsp_chan.out_ch1     = out3_ff[1];
   assign rsp_chan.out_ch2     = out3_ff[2];
   assign rsp_chan.out_ch3     = out3_ff[3];
   assign rsp_chan.src_address = src_addr3_ff;
   assign rsp_chan.dst_address = dst_addr3_ff;
   assign rsp_chan.last        = last3_ff;

endmodule

`default_nettype wire

[verif/clipped_alpha_blend_blitter_tb.sv]
// Self-checking testbench for the clipped alpha-blend blitter: drives pixel
// words and register settings, predicts every result and checks it in order.
// Depends on cabb_pkg, cabb_req_if, cabb_rsp_if and clipped_alpha_blend_blitter.
`timescale 1ns / 1ps

module clipped_alpha_blend_blitter_tb;

   localparam int QUIET_LIMIT    = 4000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASE_PIXELS   = 60;
   localparam int RANDOM_PHASES  = 20;

   typedef struct packed {
      logic            start_req;
      logic [3:0][7:0] src_ch;
      logic [3:0][7:0] dst_ch;
   } pixel_word_type;

   typedef struct packed {
      logic [3:0][7:0] out_ch;
      logic [21:0]     src_address;
      logic [21:0]     dst_address;
      logic            last;
   } blit_result_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cabb_req_if req_chan ();
   cabb_rsp_if rsp_chan ();

   clipped_alpha_blend_blitter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pixel_word_type  pixel_feed[$];
   blit_result_type expected_pixels[$];
   pixel_word_type  feed_head;
   pixel_word_type  taken_word;
   blit_result_type seen_pixel;
   blit_result_type wanted_pixel;

   // Register copies held by the predictor.
   logic signed [10:0] cfg_src_x;
   logic signed [10:0] cfg_src_y;
   logic signed [10:0] cfg_dst_x;
   logic signed [10:0] cfg_dst_y;
   logic [11:0]        cfg_copy_width;
   logic [11:0]        cfg_copy_height;
   logic               cfg_blend;
   logic [7:0]         cfg_alpha;

   // Walk position held by the predictor.
   int walk_column;
   int walk_row;
   bit walk_active;

   int send_idle_pct;
   int recv_stall_pct;
   int words_queued;
   int words_taken;
   int pixels_checked;
   int area_ends;
   int settings_loaded;
   int error_count;
   int quiet_cycles;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int clip_extent(input int org_a, input int org_b, input int len,
                                      input int lim_a, input int lim_b,
                                      output int beg_a, output int beg_b);
      int right_a;
      int right_b;
      int span_a;
      int span_b;
      beg_a   = (org_a < 0) ? 0 : org_a;
      beg_b   = (org_b < 0) ? 0 : org_b;
      right_a = (org_a + len < lim_a) ? org_a + len : lim_a;
      right_b = (org_b + len < lim_b) ? org_b + len : lim_b;
      span_a  = right_a - beg_a;
      span_b  = right_b - beg_b;
      if (span_a <= 0 || span_b <= 0) return 0;
      return (span_a < span_b) ? span_a : span_b;
   endfunction

   function automatic logic [7:0] mix_channel(input logic [7:0] s, input logic [7:0] d,
                                              input logic [7:0] a);
      int mixed;
      mixed = (int'(s) * (int'(a) + 1) + int'(d) * (256 - int'(a))) >> 8;
      return mixed[7:0];
   endfunction

   function automatic void report_error(input string what);
      error_count++;
      if (error_count <= 10) $display("[%0t] mismatch: %s", $realtime, what);
   endfunction

   // Advances the walk by one word and queues the pixel it produces, if any.
   function automatic void predict_blit_pixel(input pixel_word_type w);
      int              cols;
      int              rows;
      int              sl;
      int              dl;
      int              st;
      int              dt;
      int              sx;
      int              sy;
      int              dx;
      int              dy;
      blit_result_type res;
      cols = clip_extent(cfg_src_x, cfg_dst_x, cfg_copy_width, cabb_pkg::SRC_COLS,
                         cabb_pkg::DST_COLS, sl, dl);
      rows = clip_extent(cfg_src_y, cfg_dst_y, cfg_copy_height, cabb_pkg::SRC_ROWS,
                         cabb_pkg::DST_ROWS, st, dt);
      if (w.start_req) begin
         walk_column = 0;
         walk_row    = 0;
         walk_active = 1'b1;
      end
      if (!walk_active) return;
      if (cols <= 0 || rows <= 0 || walk_column >= cols || walk_row >= rows) begin
         walk_active = 1'b0;
         return;
      end
      sx = sl + walk_column;
      sy = st + walk_row;
      dx = dl + walk_column;
      dy = dt + walk_row;
      for (int i = 0; i < 4; i++) begin
         if (i >= cabb_pkg::MIN_BYTES_PER_PIXEL) res.out_ch[i] = w.dst_ch[i];
         else if (cfg_blend) res.out_ch[i] = mix_channel(w.src_ch[i], w.dst_ch[i], cfg_alpha);
         else res.out_ch[i] = w.src_ch[i];
      end
      res.src_address = 22'((sx + sy * cabb_pkg::SRC_COLS) * cabb_pkg::SRC_BYTES_PER_PIXEL);
      res.dst_address = 22'((dx + dy * cabb_pkg::DST_COLS) * cabb_pkg::DST_BYTES_PER_PIXEL);
      res.last        = (walk_column + 1 == cols) && (walk_row + 1 == rows);
      if (res.last) begin
         walk_active = 1'b0;
         walk_column = 0;
         walk_row    = 0;
      end else if (walk_column + 1 == cols) begin
         walk_column = 0;
         walk_row    = (walk_row + 1) & 'h7FF;
      end else begin
         walk_column = (walk_column + 1) & 'h7FF;
      end
      expected_pixels.push_back(res);
   endfunction

   // Word driver.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pixel_feed.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            feed_head = pixel_feed.pop_front();
            req_chan.valid     <= 1'b1;
            req_chan.start_req <= feed_head.start_req;
            req_chan.src_ch0   <= feed_head.src_ch[0];
            req_chan.src_ch1   <= feed_head.src_ch[1];
            req_chan.src_ch2   <= feed_head.src_ch[2];
            req_chan.src_ch3   <= feed_head.src_ch[3];
            req_chan.dst_ch0   <= feed_head.dst_ch[0];
            req_chan.dst_ch1   <= feed_head.dst_ch[1];
            req_chan.dst_ch2   <= feed_head.dst_ch[2];
            req_chan.dst_ch3   <= feed_head.dst_ch[3];
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: predicts on every accepted word and checks every accepted result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            taken_word.start_req = req_chan.start_req;
            taken_word.src_ch    = {req_chan.src_ch3, req_chan.src_ch2,
                                    req_chan.src_ch1, req_chan.src_ch0};
            taken_word.dst_ch    = {req_chan.dst_ch3, req_chan.dst_ch2,
                                    req_chan.dst_ch1, req_chan.dst_ch0};
            predict_blit_pixel(taken_word);
            words_taken++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_pixel.out_ch      = {rsp_chan.out_ch3, rsp_chan.out_ch2,
                                      rsp_chan.out_ch1, rsp_chan.out_ch0};
            seen_pixel.src_address = rsp_chan.src_address;
            seen_pixel.dst_address = rsp_chan.dst_address;
            seen_pixel.last        = rsp_chan.last;
            pixels_checked++;
            if (seen_pixel.last) area_ends++;
            if (expected_pixels.size() == 0) begin
               report_error($sformatf("unexpected result ch %h src %h dst %h last %b",
                  seen_pixel.out_ch, seen_pixel.src_address, seen_pixel.dst_address,
                  seen_pixel.last));
            end else begin
               wanted_pixel = expected_pixels.pop_front();
               if (seen_pixel.out_ch != wanted_pixel.out_ch
                   || seen_pixel.src_address != wanted_pixel.src_address
                   || seen_pixel.dst_address != wanted_pixel.dst_address
                   || seen_pixel.last != wanted_pixel.last)
                  report_error($sformatf(
                     "expected ch %h src %h dst %h last %b, got ch %h src %h dst %h last %b",
                     wanted_pixel.out_ch, wanted_pixel.src_address, wanted_pixel.dst_address,
                     wanted_pixel.last, seen_pixel.out_ch, seen_pixel.src_address,
                     seen_pixel.dst_address, seen_pixel.last));
            end
         end
      end
   end

   // Watchdog on cycles with no traffic on any port.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
                   || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[%0t] no progress, %0d results outstanding", $realtime,
                  expected_pixels.size());
         $display("clipped_alpha_blend_blitter_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_word(input logic start, input logic [31:0] src, input logic [31:0] dst);
      pixel_word_type w;
      w.start_req = start;
      w.src_ch    = src;
      w.dst_ch    = dst;
      pixel_feed.push_back(w);
      words_queued++;
   endtask

   // The register takes the value at the edge that ends the access cycle.
   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         cabb_pkg::REG_SRC_X:        cfg_src_x       = value[10:0];
         cabb_pkg::REG_SRC_Y:        cfg_src_y       = value[10:0];
         cabb_pkg::REG_DST_X:        cfg_dst_x       = value[10:0];
         cabb_pkg::REG_DST_Y:        cfg_dst_y       = value[10:0];
         cabb_pkg::REG_COPY_WIDTH:   cfg_copy_width  = value[11:0];
         cabb_pkg::REG_COPY_HEIGHT:  cfg_copy_height = value[11:0];
         cabb_pkg::REG_BLEND_ENABLE: cfg_blend       = value[0];
         cabb_pkg::REG_ALPHA:        cfg_alpha       = value[7:0];
         default: ;
      endcase
   endtask

   task automatic load_setting(input int sx, input int sy, input int dx, input int dy,
                               input int w, input int h, input int blend, input int alpha);
      csr_write(cabb_pkg::REG_SRC_X, sx & 'h7FF);
      csr_write(cabb_pkg::REG_SRC_Y, sy & 'h7FF);
      csr_write(cabb_pkg::REG_DST_X, dx & 'h7FF);
      csr_write(cabb_pkg::REG_DST_Y, dy & 'h7FF);
      csr_write(cabb_pkg::REG_COPY_WIDTH, w & 'hFFF);
      csr_write(cabb_pkg::REG_COPY_HEIGHT, h & 'hFFF);
      csr_write(cabb_pkg::REG_BLEND_ENABLE, blend & 1);
      csr_write(cabb_pkg::REG_ALPHA, alpha & 'hFF);
      settings_loaded++;
   endtask

   // Waits until every queued word is taken and every result is back, then lets
   // words that give no result leave the pipeline.
   task automatic drain();
      while (words_taken != words_queued || expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(input int phase);
      case (phase % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
         default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
   endtask

   // Origins lean towards both surface edges so that clipping is exercised.
   function automatic int random_origin();
      case ($urandom_range(3))
         0: return int'($urandom_range(15)) - 10;
         1: return 1008 + int'($urandom_range(15));
         2: return int'($urandom_range(2047)) - 1024;
         default: return int'($urandom_range(1000));
      endcase
   endfunction

   function automatic int random_length();
      case ($urandom_range(9))
         0: return int'($urandom_range(2048));
         1: return 2048;
         default: return int'($urandom_range(16, 1));
      endcase
   endfunction

   function automatic int random_alpha();
      case ($urandom_range(3))
         0: return 0;
         1: return 255;
         default: return int'($urandom_range(255));
      endcase
   endfunction

   task automatic run_phase(input int target);
      int cols;
      int rows;
      int beg_a;
      int beg_b;
      int area;
      int counted;
      int pushed;
      int len;
      int pick;
      cols = clip_extent(cfg_src_x, cfg_dst_x, cfg_copy_width, cabb_pkg::SRC_COLS,
                         cabb_pkg::DST_COLS, beg_a, beg_b);
      rows = clip_extent(cfg_src_y, cfg_dst_y, cfg_copy_height, cabb_pkg::SRC_ROWS,
                         cabb_pkg::DST_ROWS, beg_a, beg_b);
      area    = cols * rows;
      counted = 0;
      pushed  = 0;
      // Sometimes carry on with the walk left from the previous setting.
      if ($urandom_range(2) == 0) repeat (3) push_word(1'b0, $urandom, $urandom);
      if (area == 0) begin
         repeat (8) push_word(1'($urandom_range(1)), $urandom, $urandom);
      end else begin
         while (counted < target && pushed < 3 * target) begin
            pick = $urandom_range(99);
            len  = (area < 40) ? area : int'($urandom_range(40, 1));
            if (pick < 75) begin
               push_word(1'b1, $urandom, $urandom);
               for (int k = 1; k < len; k++) push_word(1'b0, $urandom, $urandom);
               if (len == area) repeat ($urandom_range(2)) push_word(1'b0, $urandom, $urandom);
               counted += len;
            end else if (pick < 92) begin
               for (int k = 0; k < len; k++)
                  push_word($urandom_range(9) == 0, $urandom, $urandom);
               counted += len / 2;
            end else begin
               repeat (3) push_word(1'b0, $urandom, $urandom);
            end
            pushed += len;
         end
      end
      drain();
   endtask

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      req_chan.valid     = 1'b0;
      req_chan.start_req = 1'b0;
      req_chan.src_ch0   = '0;
      req_chan.src_ch1   = '0;
      req_chan.src_ch2   = '0;
      req_chan.src_ch3   = '0;
      req_chan.dst_ch0   = '0;
      req_chan.dst_ch1   = '0;
      req_chan.dst_ch2   = '0;
      req_chan.dst_ch3   = '0;
      rsp_chan.ready     = 1'b0;
      cfg_src_x       = '0;
      cfg_src_y       = '0;
      cfg_dst_x       = '0;
      cfg_dst_y       = '0;
      cfg_copy_width  = '0;
      cfg_copy_height = '0;
      cfg_blend       = 1'b0;
      cfg_alpha       = 8'd255;
      walk_column     = 0;
      walk_row        = 0;
      walk_active     = 1'b0;
      set_idling(0);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // With the reset registers the area is empty: neither a restart nor an
      // idle word may give a result.
      push_word(1'b1, $urandom, $urandom);
      push_word(1'b0, $urandom, $urandom);
      drain();

      // Negative source start clamps to zero; the destination clips at its far
      // corner. Two by two pixels, then one idle word after the last.
      load_setting(-3, -2, 1021, 1022, 5, 4, 0, 255);
      push_word(1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
      push_word(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
      push_word(1'b0, $urandom, $urandom);
      push_word(1'b0, $urandom, $urandom);
      push_word(1'b0, $urandom, $urandom);
      drain();

      // Extreme origins and lengths leave a single pixel at the top source address,
      // mixed with the smallest weight.
      load_setting(1023, 1023, -1024, -1024, 2048, 2048, 1, 0);
      push_word(1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
      push_word(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
      drain();

      // Full weight, and a restart part way through a one by two walk.
      load_setting(0, 0, 1023, 0, 3, 2, 1, 255);
      push_word(1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
      push_word(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
      push_word(1'b0, $urandom, $urandom);
      push_word(1'b0, $urandom, $urandom);
      drain();

      // Zero width, then zero height.
      load_setting(5, 5, 5, 5, 0, 7, 1, 128);
      push_word(1'b1, $urandom, $urandom);
      drain();
      load_setting(5, 5, 5, 5, 7, 0, 1, 128);
      push_word(1'b1, $urandom, $urandom);
      drain();

      // Narrowing the area under a walk in progress stops it without a result.
      load_setting(0, 0, 0, 0, 4, 4, 0, 255);
      push_word(1'b1, $urandom, $urandom);
      push_word(1'b0, $urandom, $urandom);
      push_word(1'b0, $urandom, $urandom);
      drain();
      csr_write(cabb_pkg::REG_COPY_WIDTH, 1);
      push_word(1'b0, $urandom, $urandom);
      push_word(1'b0, $urandom, $urandom);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_idling(phase);
         load_setting(random_origin(), random_origin(), random_origin(), random_origin(),
                      random_length(), random_length(), $urandom_range(1), random_alpha());
         run_phase(PHASE_PIXELS);
      end

      drain();
      if (expected_pixels.size() != 0)
         report_error($sformatf("%0d results never arrived", expected_pixels.size()));
      $display("Run covered %0d words over %0d register settings and four idling patterns.",
               words_taken, settings_loaded);
      $display("Checked %0d pixels, %0d of them ending an area; %0d mismatches.",
               pixels_checked, area_ends, error_count);
      if (error_count == 0) begin
         $display("clipped_alpha_blend_blitter_tb: clean");
      end else begin
         $display("clipped_alpha_blend_blitter_tb: errors");
      end
      $finish;
   end

endmodule

[clipped_alpha_blend_blitter.f]
design/cabb_pkg.sv
design/cabb_req_if.sv
design/cabb_rsp_if.sv
design/cabb_walker.sv
design/cabb_lane.sv
design/clipped_alpha_blend_blitter.sv
verif/clipped_alpha_blend_blitter_tb.sv
